### rtl/biq_pkg.sv
// Shared types and constants for the biquad filter block.
// Depends on nothing; every other file in rtl/ imports it.
package biq_pkg;

	localparam int DIGIT_W = 8;
	localparam int X_W     = 16;
	localparam int COEF_W  = 32;
	localparam int STATE_W = 48;
	localparam int OP_W    = 32;
	localparam int X_STEPS = X_W / DIGIT_W;
	localparam int Y_STEPS = OP_W / DIGIT_W;
	localparam int STEP_W  = 2;
	localparam int ACC_W   = 34;
	localparam int LOW_W   = 32;
	localparam int SUM_W   = ACC_W + DIGIT_W;
	localparam int PP_W    = COEF_W + DIGIT_W + 1;
	localparam int FF_W    = 36;
	localparam int FB_W    = 38;

	localparam int NUM_REGS = 5;
	localparam int ADDR_W   = 5;
	localparam int IDX_W    = ADDR_W - 2;
	localparam int DATA_W   = 32;

	localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [IDX_W-1:0] REG_A2 = 3'd4;

	localparam logic [COEF_W-1:0] B0_RESET = 32'h1000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FF,
		ST_Y,
		ST_FB,
		ST_UPD,
		ST_HOLD
	} biq_state_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_set_t;

	typedef struct packed {
		logic step;
		logic first;
		logic top;
	} mul_ctl_t;

endpackage

### rtl/biq_dsmul.sv
// Digit-serial multiply cell: 32-bit coefficient times an operand fed 8 bits a cycle while ctl.step is set.
// Depends on biq_pkg.
module biq_dsmul import biq_pkg::*; (
	input  logic                     clk,
	input  mul_ctl_t                 ctl,
	input  logic [DIGIT_W-1:0]       digit,
	input  logic signed [COEF_W-1:0] coef,
	output logic signed [ACC_W-1:0]  acc_hi,
	output logic [LOW_W-1:0]         acc_lo
);

	logic signed [ACC_W-1:0] hi_q;
	logic [LOW_W-1:0]        lo_q;
	logic signed [DIGIT_W:0] dig_s;
	logic signed [PP_W-1:0]  pp;
	logic signed [ACC_W-1:0] base;
	logic signed [SUM_W-1:0] sum;

	// Top digit carries the operand sign; lower digits are unsigned.
	always_comb begin
		if (ctl.top) begin
			dig_s = $signed({digit[DIGIT_W-1], digit});
		end else begin
			dig_s = $signed({1'b0, digit});
		end
		pp   = coef * dig_s;
		base = ctl.first ? '0 : hi_q;
		sum  = SUM_W'(base) + SUM_W'(pp);
	end

	// Retire the low digit into the low shift register, keep the rest as the running high part.
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			hi_q <= sum[SUM_W-1:DIGIT_W];
			lo_q <= {sum[DIGIT_W-1:0], lo_q[LOW_W-1:DIGIT_W]};
		end
	end

	assign acc_hi = hi_q;
	assign acc_lo = lo_q;

endmodule

### rtl/biq_regs.sv
// APB coefficient register file for the biquad filter.
// Depends on biq_pkg.
module biq_regs import biq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output coef_set_t         coefs
);

	coef_set_t         coefs_q;
	logic [IDX_W-1:0]  idx;
	logic              wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign coefs  = coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.b0 <= B0_RESET;
			coefs_q.b1 <= '0;
			coefs_q.b2 <= '0;
			coefs_q.a1 <= '0;
			coefs_q.a2 <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_B0: coefs_q.b0 <= pwdata;
				REG_B1: coefs_q.b1 <= pwdata;
				REG_B2: coefs_q.b2 <= pwdata;
				REG_A1: coefs_q.a1 <= pwdata;
				REG_A2: coefs_q.a2 <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_B0: prdata = coefs_q.b0;
			REG_B1: prdata = coefs_q.b1;
			REG_B2: prdata = coefs_q.b2;
			REG_A1: prdata = coefs_q.a1;
			REG_A2: prdata = coefs_q.a2;
			default: prdata = '0;
		endcase
	end

endmodule

### rtl/biquad_iir_filter_top.sv
// Biquad IIR section, transposed direct form II, top level.
// Depends on biq_pkg, biq_dsmul and biq_regs.
//
// One signed Q1.15 sample comes in on the slave stream, one filtered Q1.15
// sample goes out on the master stream with tuser[0] set when the output was
// saturated. Five Q4.28 coefficients (b0, b1, b2, a1, a2) sit at APB byte
// addresses 0x00..0x10 and reset to a pass-through filter (b0 = 1.0); write
// them only while the filter is idle. The state is two 48-bit accumulators
// with 28 fraction bits that saturate internally. Three digit-serial multiply
// cells share each operand 8 bits a cycle: the sample takes 2 digit steps
// (b0, b1, b2 at once), the feedback term takes 4 (a1, a2 at once). The word is
// accepted in ST_IDLE, y is formed in ST_Y and the state is written back in
// ST_UPD. A finished word waits in the output register while the next one is
// accepted, and the sequencer holds a second finished word, taking no new
// sample, until the first is taken.
module biquad_iir_filter_top import biq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [15:0] sample_in
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [15:0] sample_out
	output logic [0:0]        m_tuser,   // [0] clipped
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam logic signed [STATE_W-1:0] S48_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] S48_MIN = {1'b1, {(STATE_W-1){1'b0}}};

	// Saturate a widened sum back to the 48-bit state range.
	function automatic logic signed [STATE_W-1:0] sat48(input logic signed [STATE_W+1:0] v);
		logic [2:0] top;
		top = v[STATE_W+1:STATE_W-1];
		if (top == 3'b000 || top == 3'b111) begin
			return v[STATE_W-1:0];
		end
		return v[STATE_W+1] ? S48_MIN : S48_MAX;
	endfunction

	// x*b >> 15 with round half up, from the cell's high part and low 16 bits.
	function automatic logic signed [FF_W-1:0] ff_term(
		input logic signed [ACC_W-1:0] hi,
		input logic [15:0] lo
	);
		logic [16:0] rnd;
		rnd = {1'b0, lo} + 17'h0_4000;
		return (FF_W'(hi) <<< 1) + FF_W'(rnd[16:15]);
	endfunction

	// y*a >> 28 with round half up, from the cell's high part and low 32 bits.
	function automatic logic signed [FB_W-1:0] fb_term(
		input logic signed [ACC_W-1:0] hi,
		input logic [LOW_W-1:0] lo
	);
		logic [LOW_W:0] rnd;
		rnd = {1'b0, lo} + 33'h0_0800_0000;
		return (FB_W'(hi) <<< 4) + FB_W'(rnd[LOW_W:28]);
	endfunction

	coef_set_t coefs;

	biq_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [OP_W-1:0]   op_q, op_d;
	mul_ctl_t          ctl;
	logic              fb_sel;
	logic              ld_y;
	logic              ld_upd;
	logic              push;
	logic              out_free;

	logic signed [STATE_W-1:0] d1_q, d2_q;
	logic signed [FF_W-1:0]    ff1_q, ff2_q;
	logic [15:0]               res_data_q;
	logic                      res_clip_q;
	logic                      out_valid_q;
	logic [15:0]               out_data_q;
	logic                      out_clip_q;

	logic signed [ACC_W-1:0] hi0, hi1, hi2;
	logic [LOW_W-1:0]        lo0, lo1, lo2;
	logic signed [COEF_W-1:0] coef1, coef2;

	logic signed [FF_W-1:0]    ff0, ff1, ff2;
	logic signed [STATE_W:0]   y_sum;
	logic signed [STATE_W-1:0] y;
	logic signed [OP_W-1:0]    yfb;
	logic signed [STATE_W:0]   y_rnd;
	logic signed [35:0]        y_shr;
	logic [15:0]               o_data;
	logic                      o_clip;
	logic signed [FB_W-1:0]    fb1, fb2;
	logic signed [STATE_W+1:0] n1, n2;

	biq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	// Cells 1 and 2 switch from b1/b2 to a1/a2 for the feedback pass.
	assign coef1 = fb_sel ? coefs.a1 : coefs.b1;
	assign coef2 = fb_sel ? coefs.a2 : coefs.b2;

	biq_dsmul u_mul0 (
		.clk    (clk),
		.ctl    (ctl),
		.digit  (op_q[DIGIT_W-1:0]),
		.coef   (coefs.b0),
		.acc_hi (hi0),
		.acc_lo (lo0)
	);

	biq_dsmul u_mul1 (
		.clk    (clk),
		.ctl    (ctl),
		.digit  (op_q[DIGIT_W-1:0]),
		.coef   (coef1),
		.acc_hi (hi1),
		.acc_lo (lo1)
	);

	biq_dsmul u_mul2 (
		.clk    (clk),
		.ctl    (ctl),
		.digit  (op_q[DIGIT_W-1:0]),
		.coef   (coef2),
		.acc_hi (hi2),
		.acc_lo (lo2)
	);

	// Output y and the feedback operand, valid in ST_Y once the sample digits are done.
	always_comb begin
		ff0   = ff_term(hi0, lo0[LOW_W-1:LOW_W-X_W]);
		ff1   = ff_term(hi1, lo1[LOW_W-1:LOW_W-X_W]);
		ff2   = ff_term(hi2, lo2[LOW_W-1:LOW_W-X_W]);
		y_sum = (STATE_W+1)'(ff0) + (STATE_W+1)'(d1_q);
		y     = sat48((STATE_W+2)'(y_sum));
		// Clamp y to Q4.28 for the feedback multiplies.
		if (y[STATE_W-1:OP_W-1] == '0 || y[STATE_W-1:OP_W-1] == '1) begin
			yfb = y[OP_W-1:0];
		end else begin
			yfb = y[STATE_W-1] ? {1'b1, {(OP_W-1){1'b0}}} : {1'b0, {(OP_W-1){1'b1}}};
		end
		// Round to Q1.15 and saturate; only this clamp raises the flag.
		y_rnd = (STATE_W+1)'(y) + (STATE_W+1)'(4096);
		y_shr = y_rnd[STATE_W:13];
		if (y_shr[35:15] == '0 || y_shr[35:15] == '1) begin
			o_data = y_shr[15:0];
			o_clip = 1'b0;
		end else begin
			o_data = y_shr[35] ? 16'h8000 : 16'h7fff;
			o_clip = 1'b1;
		end
	end

	// New state, valid in ST_UPD once the feedback digits are done.
	always_comb begin
		fb1 = fb_term(hi1, lo1);
		fb2 = fb_term(hi2, lo2);
		n1  = (STATE_W+2)'(ff1_q) - (STATE_W+2)'(fb1) + (STATE_W+2)'(d2_q);
		n2  = (STATE_W+2)'(ff2_q) - (STATE_W+2)'(fb2);
	end

	assign out_free = !out_valid_q || m_tready;

	// Sequencer: accept, sample digits, form y, feedback digits, write back, and hold while the output register is full.
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		op_d     = op_q;
		s_tready = 1'b0;
		ctl      = '0;
		fb_sel   = 1'b0;
		ld_y     = 1'b0;
		ld_upd   = 1'b0;
		push     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					op_d    = OP_W'($signed(s_tdata));
					step_d  = '0;
					state_d = ST_FF;
				end
			end
			ST_FF: begin
				ctl.step  = 1'b1;
				ctl.first = (step_q == '0);
				ctl.top   = (step_q == STEP_W'(X_STEPS - 1));
				op_d      = op_q >> DIGIT_W;
				if (ctl.top) begin
					step_d  = '0;
					state_d = ST_Y;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_Y: begin
				ld_y    = 1'b1;
				op_d    = yfb;
				state_d = ST_FB;
			end
			ST_FB: begin
				fb_sel    = 1'b1;
				ctl.step  = 1'b1;
				ctl.first = (step_q == '0);
				ctl.top   = (step_q == STEP_W'(Y_STEPS - 1));
				op_d      = op_q >> DIGIT_W;
				if (ctl.top) begin
					step_d  = '0;
					state_d = ST_UPD;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_UPD: begin
				fb_sel = 1'b1;
				ld_upd = 1'b1;
				if (out_free) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				// Hold the finished word until the output register frees up.
				if (out_free) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			d1_q        <= '0;
			d2_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (ld_upd) begin
				d1_q <= sat48(n1);
				d2_q <= sat48(n2);
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		if (ld_y) begin
			ff1_q      <= ff1;
			ff2_q      <= ff2;
			res_data_q <= o_data;
			res_clip_q <= o_clip;
		end
		if (push) begin
			out_data_q <= res_data_q;
			out_clip_q <= res_clip_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_clip_q;

`ifndef NO_ASSERTIONS
	a_accept_starts_ff: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_FF && step_q == '0)
		else $error("accepted word did not start the sample digit pass");

	a_ff_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FF |-> step_q <= STEP_W'(X_STEPS - 1))
		else $error("sample digit counter ran past the last digit");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
		else $error("clip flag set on a word that is not full scale");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD && out_valid_q && !m_tready |=> state_q == ST_HOLD)
		else $error("finished word not held while output register is full");
`endif

endmodule
